>>> rtl/cksum_pkg.sv
package cksum_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 16;

   localparam logic [WORD_W-1:0] HIGH_MASK = 16'hFF00;
   localparam logic [WORD_W-1:0] LOW_MASK  = 16'h00FF;
   localparam logic [WORD_W-1:0] ALL_ONES  = 16'hFFFF;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] checksum;
      logic              checksum_ok;
   } rsp_type;

   // 16-bit add with end-around carry
   function automatic logic [WORD_W-1:0] add_ones_complement(
      input logic [WORD_W-1:0] acc,
      input logic [WORD_W-1:0] word
   );
      logic [WORD_W:0] sum;
      sum = {1'b0, acc} + {1'b0, word};
      if (sum[WORD_W]) begin
         return sum[WORD_W-1:0] + WORD_W'(1);
      end
      return sum[WORD_W-1:0];
   endfunction

   // exchange high and low bytes
   function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] value);
      return ((value & LOW_MASK) << BYTE_W) | ((value & HIGH_MASK) >> BYTE_W);
   endfunction

endpackage

>>> rtl/ones_complement_byte_checksum.sv
// A record's last byte passes from the input register into the result register,
// which drives rsp_valid; a full result slot holds it back in the input stage.
// Throughput: one byte per cycle unless a last byte waits on a full slot; set by
// the single 16-bit end-around add between the input register and the running sum.
// Reset (synchronous, active high) empties both stages and clears the running
// sum, the held high byte and the odd-position flag.
module ones_complement_byte_checksum (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cksum_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cksum_pkg::rsp_type rsp_payload
);

   logic               item_valid;
   cksum_pkg::req_type item;
   logic               advance;
   logic               out_free;
   logic               load;
   logic               odd_position;
   cksum_pkg::rsp_type result;

   // a byte leaves the input stage unless it is a last byte facing a full slot
   assign advance = item_valid && (!item.last_byte || out_free);
   assign load    = advance && item.last_byte;

   cksum_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   cksum_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .item         (item),
      .result       (result),
      .odd_position (odd_position)
   );

   cksum_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .result      (result),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // a finished record always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("record end did not produce a result");

   // state is cleared after a record ends
   assert property (@(posedge clock) disable iff (reset)
      load |=> !odd_position)
      else $error("odd position not cleared after record end");

   // pass flag agrees with the checksum value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.checksum_ok == (rsp_payload.checksum == 16'h0000)))
      else $error("pass flag disagrees with checksum");

   // an empty input stage always takes a byte
   assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> req_ready)
      else $error("input stage empty but not ready");

endmodule

>>> rtl/cksum_in_reg.sv
module cksum_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cksum_pkg::req_type req_payload,
   input  logic               advance,
   output logic               item_valid,
   output cksum_pkg::req_type item
);

   logic               valid_ff;
   logic               valid_in;
   cksum_pkg::req_type item_ff;

   // take a new byte when the stage is empty or draining this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_valid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load payload on each transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/cksum_accum.sv
module cksum_accum (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  cksum_pkg::req_type                 item,
   output cksum_pkg::rsp_type                 result,
   output logic                               odd_position
);

   logic [cksum_pkg::WORD_W-1:0] running_sum_ff;
   logic [cksum_pkg::WORD_W-1:0] running_sum_in;
   logic [cksum_pkg::BYTE_W-1:0] held_high_byte_ff;
   logic [cksum_pkg::BYTE_W-1:0] held_high_byte_in;
   logic                         odd_position_ff;
   logic                         odd_position_in;
   logic [cksum_pkg::WORD_W-1:0] word;
   logic [cksum_pkg::WORD_W-1:0] folded;
   logic [cksum_pkg::WORD_W-1:0] shaped;
   logic [cksum_pkg::WORD_W-1:0] inverted;

   // pair the byte with the held high byte, or pad with a zero low byte
   assign word = odd_position_ff ? {held_high_byte_ff, item.data_byte}
                                 : {item.data_byte, cksum_pkg::BYTE_W'(0)};
   assign folded   = cksum_pkg::add_ones_complement(running_sum_ff, word);
   assign shaped   = odd_position_ff ? folded : cksum_pkg::swap_bytes(folded);
   assign inverted = shaped ^ cksum_pkg::ALL_ONES;

   assign result.checksum    = inverted;
   assign result.checksum_ok = (inverted == cksum_pkg::WORD_W'(0));

   // next state: hold a high byte, fold a word in, or clear at record end
   always_comb begin
      running_sum_in    = running_sum_ff;
      held_high_byte_in = held_high_byte_ff;
      odd_position_in   = odd_position_ff;
      if (advance) begin
         priority if (item.last_byte) begin
            running_sum_in    = '0;
            held_high_byte_in = '0;
            odd_position_in   = 1'b0;
         end else if (!odd_position_ff) begin
            held_high_byte_in = item.data_byte;
            odd_position_in   = 1'b1;
         end else begin
            running_sum_in    = folded;
            held_high_byte_in = '0;
            odd_position_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff    <= '0;
         held_high_byte_ff <= '0;
         odd_position_ff   <= 1'b0;
      end else begin
         running_sum_ff    <= running_sum_in;
         held_high_byte_ff <= held_high_byte_in;
         odd_position_ff   <= odd_position_in;
      end
   end

   assign odd_position = odd_position_ff;

endmodule

>>> rtl/cksum_out_reg.sv
module cksum_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  cksum_pkg::rsp_type result,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cksum_pkg::rsp_type rsp_payload
);

   logic               valid_ff;
   logic               valid_in;
   cksum_pkg::rsp_type payload_ff;

   // slot frees up when empty or when the held result transfers now
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule
